[rtl/core/uhfdm_pkg.sv]
// Shared types and constants for the unit hydrograph FIR with daily mean.
package uhfdm_pkg;

    // Tap row geometry (MAX_TAPS must be a power of two for the adder tree)
    localparam int MAX_TAPS  = 32;
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = 6;
    localparam int TREE_LVLS = $clog2(MAX_TAPS);

    // Payload widths
    localparam int OPCODE_W  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + TREE_LVLS;
    localparam int FLOW_W    = 40;
    localparam int PART_W    = 42;
    localparam int TOT_W     = PART_W + 1;
    localparam int PHASE_W   = 2;

    // Stream word layout
    localparam int S_FIELD_W = SAMPLE_W + TAP_IDX_W + COEF_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 2 * FLOW_W;

    // Reset and boundary values
    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = TAP_CNT_W'(19);
    localparam logic [PHASE_W-1:0]   LAST_PHASE  = PHASE_W'(3);

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_SAMPLE  = OPCODE_W'(0);
    localparam logic [OPCODE_W-1:0] OP_LOAD    = OPCODE_W'(1);
    localparam logic [OPCODE_W-1:0] OP_RESTART = OPCODE_W'(2);

    // Token travelling alongside the data pipeline
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SAMPLE,
        KIND_RESTART
    } t_kind;

    // Per-cycle control broadcast to every tap cell
    typedef struct packed {
        logic shift;
        logic clear;
        logic advance;
    } t_cell_ctl;

endpackage

[rtl/core/uhfdm_cell.sv]
// One tap cell: holds a history sample and a coefficient, registers their product.
module uhfdm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  uhfdm_pkg::t_cell_ctl         i_ctl,
    input  logic [uhfdm_pkg::SAMPLE_W-1:0] i_sample,
    output logic [uhfdm_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                         i_coef_we,
    input  logic [uhfdm_pkg::COEF_W-1:0] i_coef,
    input  logic                         i_tap_on,
    output logic [uhfdm_pkg::PROD_W-1:0] o_prod
);

    logic [uhfdm_pkg::SAMPLE_W-1:0] r_sample;
    logic [uhfdm_pkg::SAMPLE_W-1:0] n_sample;
    logic [uhfdm_pkg::COEF_W-1:0]   r_coef;
    logic [uhfdm_pkg::PROD_W-1:0]   r_prod;
    logic [uhfdm_pkg::PROD_W-1:0]   n_prod;

    // Take the neighbour's sample on a shift, drop history on a restart
    always_comb begin
        if (i_ctl.clear) begin
            n_sample = '0;
        end else if (i_ctl.shift) begin
            n_sample = i_sample;
        end else begin
            n_sample = r_sample;
        end
    end

    // Multiply the fresh history sample by this tap's coefficient
    always_comb begin
        if (i_tap_on) begin
            n_prod = uhfdm_pkg::PROD_W'(n_sample) * uhfdm_pkg::PROD_W'(r_coef);
        end else begin
            n_prod = '0;
        end
    end

    // Hold the delay line word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    // Coefficient and product carry no reset
    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef <= i_coef;
        end
        if (i_ctl.advance) begin
            r_prod <= n_prod;
        end
    end

    assign o_sample = r_sample;
    assign o_prod   = r_prod;

endmodule

[rtl/core/uhfdm_adder_tree.sv]
// Registered binary adder tree summing the tap products, one level per stage.
module uhfdm_adder_tree (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [uhfdm_pkg::PROD_W-1:0] i_prod [uhfdm_pkg::MAX_TAPS],
    input  uhfdm_pkg::t_kind             i_kind,
    output logic [uhfdm_pkg::ACC_W-1:0]  o_sum,
    output uhfdm_pkg::t_kind             o_kind
);

    localparam int NODES = uhfdm_pkg::MAX_TAPS - 1;

    // Heap order: node i has children 2i+1 and 2i+2, leaves follow the nodes
    logic [uhfdm_pkg::ACC_W-1:0] r_node [NODES];
    logic [uhfdm_pkg::ACC_W-1:0] n_node [NODES];
    uhfdm_pkg::t_kind            r_kind [uhfdm_pkg::TREE_LVLS];

    // Add each pair of children, taking leaves straight from the products
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            if (2 * i + 1 >= NODES) begin
                n_node[i] = uhfdm_pkg::ACC_W'(i_prod[2 * i + 1 - NODES])
                          + uhfdm_pkg::ACC_W'(i_prod[2 * i + 2 - NODES]);
            end else begin
                n_node[i] = r_node[2 * i + 1] + r_node[2 * i + 2];
            end
        end
    end

    // Advance the partial sums
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int i = 0; i < NODES; i++) begin
                r_node[i] <= n_node[i];
            end
        end
    end

    // Advance the token alongside the sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < uhfdm_pkg::TREE_LVLS; l++) begin
                r_kind[l] <= uhfdm_pkg::KIND_NONE;
            end
        end else if (i_advance) begin
            r_kind[0] <= i_kind;
            for (int l = 1; l < uhfdm_pkg::TREE_LVLS; l++) begin
                r_kind[l] <= r_kind[l - 1];
            end
        end
    end

    assign o_sum  = r_node[0];
    assign o_kind = r_kind[uhfdm_pkg::TREE_LVLS - 1];

endmodule

[rtl/core/uhfdm_daily.sv]
// Day accumulator and output register: instantaneous flow plus weighted daily mean.
module uhfdm_daily (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  uhfdm_pkg::t_kind             i_kind,
    input  logic [uhfdm_pkg::ACC_W-1:0]  i_sum,
    output logic                         o_valid,
    output logic [uhfdm_pkg::FLOW_W-1:0] o_instant,
    output logic                         o_daily_valid,
    output logic [uhfdm_pkg::FLOW_W-1:0] o_daily
);

    logic [uhfdm_pkg::FLOW_W-1:0]  w_flow;
    logic [uhfdm_pkg::TOT_W-1:0]   w_total;

    logic [uhfdm_pkg::PHASE_W-1:0] r_phase;
    logic [uhfdm_pkg::PART_W-1:0]  r_partial;
    logic [uhfdm_pkg::FLOW_W-1:0]  r_prev;
    logic                          r_valid;
    logic [uhfdm_pkg::FLOW_W-1:0]  r_instant;
    logic                          r_daily_valid;
    logic [uhfdm_pkg::FLOW_W-1:0]  r_daily;

    assign w_flow  = uhfdm_pkg::FLOW_W'(i_sum);
    // Boundary samples weigh once, inner samples twice (already doubled)
    assign w_total = uhfdm_pkg::TOT_W'(r_prev) + uhfdm_pkg::TOT_W'(r_partial)
                   + uhfdm_pkg::TOT_W'(w_flow);

    // Update day state in sample order, clear it on a restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_partial <= '0;
            r_prev    <= '0;
            r_valid   <= 1'b0;
        end else if (i_advance) begin
            r_valid <= (i_kind == uhfdm_pkg::KIND_SAMPLE);
            case (i_kind)
                uhfdm_pkg::KIND_SAMPLE: begin
                    if (r_phase == uhfdm_pkg::LAST_PHASE) begin
                        r_phase   <= '0;
                        r_partial <= '0;
                        r_prev    <= w_flow;
                    end else begin
                        r_phase   <= r_phase + 1'b1;
                        r_partial <= r_partial
                                   + uhfdm_pkg::PART_W'({w_flow, 1'b0});
                    end
                end
                uhfdm_pkg::KIND_RESTART: begin
                    r_phase   <= '0;
                    r_partial <= '0;
                    r_prev    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_instant <= w_flow;
            if (r_phase == uhfdm_pkg::LAST_PHASE) begin
                r_daily_valid <= 1'b1;
                r_daily       <= w_total[uhfdm_pkg::FLOW_W+2:3];
            end else begin
                r_daily_valid <= 1'b0;
                r_daily       <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_instant     = r_instant;
    assign o_daily_valid = r_daily_valid;
    assign o_daily       = r_daily;

endmodule

[rtl/core/unit_hydrograph_fir_daily_mean.sv]
// A sample word passes registered stages in order: cell, 5 tree levels, day.
// Throughput: one word per cycle; the tap cells and adder tree form one pipeline
// that holds as a whole only while the output word is waiting to be taken.
// Load and restart words take one slot and give no result.
// Reset: synchronous, active low; clears history, day state, pipeline tokens and
// sets tap_count to 19; coefficients are not reset and must be loaded before use.
module unit_hydrograph_fir_daily_mean (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: tap_count
    input  logic                            i_cfg_we,
    input  logic [uhfdm_pkg::TAP_CNT_W-1:0] i_cfg_wdata,
    // Input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: inflow[15:0], tap_index[20:16], coef_value[36:21], zero[39:37]
    input  logic [uhfdm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [uhfdm_pkg::OPCODE_W-1:0]  i_s_tuser,
    // Output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: instant_flow[39:0], daily_flow[79:40]
    output logic [uhfdm_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser: daily_valid[0]
    output logic                            o_m_tuser
);

    logic                            w_advance;
    logic                            w_accept;
    uhfdm_pkg::t_cell_ctl            w_ctl;
    logic                            w_load;
    logic [uhfdm_pkg::SAMPLE_W-1:0]  w_inflow;
    logic [uhfdm_pkg::TAP_IDX_W-1:0] w_tap_index;
    logic [uhfdm_pkg::COEF_W-1:0]    w_coef_value;
    uhfdm_pkg::t_kind                n_kind;

    logic [uhfdm_pkg::TAP_CNT_W-1:0] r_tap_count;
    uhfdm_pkg::t_kind                r_kind;

    logic [uhfdm_pkg::SAMPLE_W-1:0]  w_hist [uhfdm_pkg::MAX_TAPS];
    logic [uhfdm_pkg::PROD_W-1:0]    w_prod [uhfdm_pkg::MAX_TAPS];
    logic [uhfdm_pkg::ACC_W-1:0]     w_sum;
    uhfdm_pkg::t_kind                w_tree_kind;

    logic                            w_out_valid;
    logic [uhfdm_pkg::FLOW_W-1:0]    w_instant;
    logic                            w_daily_valid;
    logic [uhfdm_pkg::FLOW_W-1:0]    w_daily;

    // Unpack the input word
    assign w_inflow     = i_s_tdata[uhfdm_pkg::SAMPLE_W-1:0];
    assign w_tap_index  = i_s_tdata[uhfdm_pkg::SAMPLE_W +: uhfdm_pkg::TAP_IDX_W];
    assign w_coef_value = i_s_tdata[uhfdm_pkg::SAMPLE_W + uhfdm_pkg::TAP_IDX_W +:
                                    uhfdm_pkg::COEF_W];

    // Advance the whole pipeline unless the output word is stuck
    assign w_advance  = !w_out_valid || i_m_tready;
    assign o_s_tready = w_advance;
    assign w_accept   = i_s_tvalid && w_advance;

    // Decode the opcode into cell controls and a pipeline token
    always_comb begin
        w_ctl.shift   = 1'b0;
        w_ctl.clear   = 1'b0;
        w_ctl.advance = w_advance;
        w_load        = 1'b0;
        n_kind        = uhfdm_pkg::KIND_NONE;
        if (w_accept) begin
            unique case (i_s_tuser)
                uhfdm_pkg::OP_SAMPLE: begin
                    w_ctl.shift = 1'b1;
                    n_kind      = uhfdm_pkg::KIND_SAMPLE;
                end
                uhfdm_pkg::OP_LOAD: begin
                    w_load = 1'b1;
                end
                uhfdm_pkg::OP_RESTART: begin
                    w_ctl.clear = 1'b1;
                    n_kind      = uhfdm_pkg::KIND_RESTART;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the tap count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= uhfdm_pkg::TAP_CNT_RST;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    // Token for the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= uhfdm_pkg::KIND_NONE;
        end else if (w_advance) begin
            r_kind <= n_kind;
        end
    end

    // Row of tap cells, each passing its sample to the next
    for (genvar j = 0; j < uhfdm_pkg::MAX_TAPS; j++) begin : g_cell
        logic [uhfdm_pkg::SAMPLE_W-1:0] w_cell_in;
        logic                           w_coef_we;
        logic                           w_tap_on;

        if (j == 0) begin : g_head
            assign w_cell_in = w_inflow;
        end else begin : g_link
            assign w_cell_in = w_hist[j - 1];
        end

        assign w_coef_we = w_load && (w_tap_index == uhfdm_pkg::TAP_IDX_W'(j));
        assign w_tap_on  = uhfdm_pkg::TAP_CNT_W'(j) < r_tap_count;

        uhfdm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_sample  (w_cell_in),
            .o_sample  (w_hist[j]),
            .i_coef_we (w_coef_we),
            .i_coef    (w_coef_value),
            .i_tap_on  (w_tap_on),
            .o_prod    (w_prod[j])
        );
    end

    // Sum the products
    uhfdm_adder_tree u_tree (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_prod    (w_prod),
        .i_kind    (r_kind),
        .o_sum     (w_sum),
        .o_kind    (w_tree_kind)
    );

    // Daily mean and output register
    uhfdm_daily u_daily (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_kind        (w_tree_kind),
        .i_sum         (w_sum),
        .o_valid       (w_out_valid),
        .o_instant     (w_instant),
        .o_daily_valid (w_daily_valid),
        .o_daily       (w_daily)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_daily, w_instant};
    assign o_m_tuser  = w_daily_valid;

endmodule
